>>> hdl/scov_pkg.sv
// scov_pkg: shared types and constants for the shaded circle overlay
// holds the geometry bundle, register indexes, reciprocal constants and colours
// no dependencies
package scov_pkg;

    // configuration register widths and indexes
    localparam int CFG_W      = 12;
    localparam int CFG_ADDR_W = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // frame phase counter
    localparam int              PHASE_W    = 6;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 6'd59;

    // geometry widths
    localparam int GEOM_W = 12;   // centre coordinates
    localparam int DY_W   = 14;   // signed vertical offset of the ball
    localparam int THR_W  = 18;   // squared band radii

    // reciprocal constants: floor(x*K >> N) equals the exact quotient for 12-bit x (9-bit x for /6 and /3)
    localparam logic [11:0] K_DIV10 = 12'd3277;   // N = 15
    localparam logic [12:0] K_DIV60 = 13'd4370;   // N = 18
    localparam logic [9:0]  K_DIV6  = 10'd683;    // N = 12, and N = 11 gives /3
    localparam logic [14:0] K_ISQ8  = 15'd23170;  // N = 16, 1/(2*sqrt2) rounded down

    // geometry settle time after reset or a register write
    localparam int          SETTLE_W = 4;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 4'd9;

    // band colours (red is always full)
    localparam logic [7:0] COL_FULL  = 8'hFF;
    localparam logic [7:0] COL_BAND1 = 8'hAA;
    localparam logic [7:0] COL_BAND2 = 8'h8D;
    localparam logic [7:0] COL_BAND3 = 8'h4F;
    localparam logic [7:0] COL_BALL  = 8'h00;

    // geometry that stays fixed for a frame size, but dy_init also follows the frame phase
    typedef struct packed {
        logic [CFG_W-1:0]         width;
        logic [CFG_W-1:0]         height;
        logic [GEOM_W-1:0]        cx;
        logic [GEOM_W-1:0]        lx;
        logic [GEOM_W-2:0]        h2;
        logic [GEOM_W-2:0]        h2mo;
        logic [6:0]               hq;
        logic signed [DY_W-1:0]   dy_init;
        logic [THR_W-1:0]         thr_band1;
        logic [THR_W-1:0]         thr_band2;
        logic [THR_W-1:0]         thr_band3;
        logic [THR_W-1:0]         thr_ball;
    } t_geom;

endpackage

>>> hdl/scov_geometry.sv
// scov_geometry: frame size registers and the pipelined unit that derives
// ball centre, radius, highlight offset and band thresholds from them
// depends on scov_pkg
module scov_geometry (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [scov_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [scov_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [scov_pkg::PHASE_W-1:0]    i_phase,
    output scov_pkg::t_geom                 o_geom,
    output logic                            o_busy
);

    // (k+1)^2 for the band radius tests
    function automatic logic [scov_pkg::THR_W-1:0] sq_inc(input logic [8:0] k);
        logic [scov_pkg::THR_W-1:0] kp;
        kp = scov_pkg::THR_W'(k) + scov_pkg::THR_W'(1);
        return kp * kp;
    endfunction

    logic [scov_pkg::CFG_W-1:0]    r_width;
    logic [scov_pkg::CFG_W-1:0]    r_height;
    logic [scov_pkg::SETTLE_W-1:0] r_settle;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= scov_pkg::WIDTH_RESET;
            r_height <= scov_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (scov_pkg::t_cfg_idx'(i_cfg_addr))
                scov_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_wdata;
                scov_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // settle counter, restarted by reset and every write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= scov_pkg::SETTLE_CYCLES;
        end else if (i_cfg_we) begin
            r_settle <= scov_pkg::SETTLE_CYCLES;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - scov_pkg::SETTLE_W'(1);
        end
    end

    assign o_busy = (r_settle != '0);

    // stage 1: smaller side, half sizes
    logic [scov_pkg::CFG_W-1:0]    r_g1_m, r_g1_h;
    logic [scov_pkg::GEOM_W-1:0]   r_g1_cx;
    logic [scov_pkg::GEOM_W-2:0]   r_g1_h2;
    // stage 2: reciprocal products for /10 and /60
    logic [23:0]                   r_g2_pr;
    logic [24:0]                   r_g2_ph;
    logic [scov_pkg::GEOM_W-1:0]   r_g2_cx;
    logic [scov_pkg::GEOM_W-2:0]   r_g2_h2;
    // stage 3: radius and row step
    logic [8:0]                    r_g3_r;
    logic [6:0]                    r_g3_hq;
    logic [scov_pkg::GEOM_W-1:0]   r_g3_cx;
    logic [scov_pkg::GEOM_W-2:0]   r_g3_h2;
    // stage 4: products on the radius and phase
    logic [18:0]                   r_g4_p6;
    logic [23:0]                   r_g4_po;
    logic [scov_pkg::THR_W-1:0]    r_g4_rsq;
    logic [12:0]                   r_g4_hqp;
    logic [8:0]                    r_g4_r;
    logic [6:0]                    r_g4_hq;
    logic [scov_pkg::GEOM_W-1:0]   r_g4_cx;
    logic [scov_pkg::GEOM_W-2:0]   r_g4_h2;
    // stage 5: band radii, offset estimate, initial vertical offset
    logic [6:0]                    r_g5_k6, r_g5_k4;
    logic [7:0]                    r_g5_k3, r_g5_o0;
    logic [8:0]                    r_g5_r;
    logic [scov_pkg::THR_W-1:0]    r_g5_rsq;
    logic signed [scov_pkg::DY_W-1:0] r_g5_dy;
    logic [6:0]                    r_g5_hq;
    logic [scov_pkg::GEOM_W-1:0]   r_g5_cx;
    logic [scov_pkg::GEOM_W-2:0]   r_g5_h2;
    // stage 6: squared thresholds and offset check
    logic [scov_pkg::THR_W-1:0]    r_g6_t1, r_g6_t2, r_g6_t3, r_g6_t0, r_g6_q, r_g6_rsq;
    logic [7:0]                    r_g6_o0;
    logic signed [scov_pkg::DY_W-1:0] r_g6_dy;
    logic [6:0]                    r_g6_hq;
    logic [scov_pkg::GEOM_W-1:0]   r_g6_cx;
    logic [scov_pkg::GEOM_W-2:0]   r_g6_h2;
    // stage 7: final offset and highlight centre
    logic [scov_pkg::GEOM_W-1:0]   r_g7_cx, r_g7_lx;
    logic [scov_pkg::GEOM_W-2:0]   r_g7_h2, r_g7_h2mo;
    logic [6:0]                    r_g7_hq;
    logic signed [scov_pkg::DY_W-1:0] r_g7_dy;
    logic [scov_pkg::THR_W-1:0]    r_g7_t1, r_g7_t2, r_g7_t3, r_g7_t0;

    logic [7:0] n_o;

    assign n_o = (r_g6_q <= r_g6_rsq) ? (r_g6_o0 + 8'd1) : r_g6_o0;

    // free-running derivation pipeline
    always_ff @(posedge i_clk) begin
        r_g1_m  <= (r_height < r_width) ? r_height : r_width;
        r_g1_h  <= r_height;
        r_g1_cx <= scov_pkg::GEOM_W'(r_width >> 1);
        r_g1_h2 <= (scov_pkg::GEOM_W-1)'(r_height >> 1);

        r_g2_pr <= 24'(r_g1_m) * 24'(scov_pkg::K_DIV10);
        r_g2_ph <= 25'(r_g1_h) * 25'(scov_pkg::K_DIV60);
        r_g2_cx <= r_g1_cx;
        r_g2_h2 <= r_g1_h2;

        r_g3_r  <= 9'(r_g2_pr >> 15);
        r_g3_hq <= 7'(r_g2_ph >> 18);
        r_g3_cx <= r_g2_cx;
        r_g3_h2 <= r_g2_h2;

        r_g4_p6  <= 19'(r_g3_r) * 19'(scov_pkg::K_DIV6);
        r_g4_po  <= 24'(r_g3_r) * 24'(scov_pkg::K_ISQ8);
        r_g4_rsq <= scov_pkg::THR_W'(r_g3_r) * scov_pkg::THR_W'(r_g3_r);
        r_g4_hqp <= 13'(r_g3_hq) * 13'(i_phase);
        r_g4_r   <= r_g3_r;
        r_g4_hq  <= r_g3_hq;
        r_g4_cx  <= r_g3_cx;
        r_g4_h2  <= r_g3_h2;

        r_g5_k6  <= 7'(r_g4_p6 >> 12);
        r_g5_k3  <= 8'(r_g4_p6 >> 11);
        r_g5_k4  <= 7'(r_g4_r >> 2);
        r_g5_o0  <= 8'(r_g4_po >> 16);
        r_g5_r   <= r_g4_r;
        r_g5_rsq <= r_g4_rsq;
        r_g5_dy  <= $signed(scov_pkg::DY_W'(r_g4_h2)) - $signed(scov_pkg::DY_W'(r_g4_hqp));
        r_g5_hq  <= r_g4_hq;
        r_g5_cx  <= r_g4_cx;
        r_g5_h2  <= r_g4_h2;

        r_g6_t1  <= sq_inc(9'(r_g5_k6));
        r_g6_t2  <= sq_inc(9'(r_g5_k4));
        r_g6_t3  <= sq_inc(9'(r_g5_k3));
        r_g6_t0  <= sq_inc(r_g5_r);
        r_g6_q   <= sq_inc(9'(r_g5_o0)) << 3;
        r_g6_rsq <= r_g5_rsq;
        r_g6_o0  <= r_g5_o0;
        r_g6_dy  <= r_g5_dy;
        r_g6_hq  <= r_g5_hq;
        r_g6_cx  <= r_g5_cx;
        r_g6_h2  <= r_g5_h2;

        r_g7_cx   <= r_g6_cx;
        r_g7_lx   <= r_g6_cx - scov_pkg::GEOM_W'(n_o);
        r_g7_h2   <= r_g6_h2;
        r_g7_h2mo <= r_g6_h2 - (scov_pkg::GEOM_W-1)'(n_o);
        r_g7_hq   <= r_g6_hq;
        r_g7_dy   <= r_g6_dy;
        r_g7_t1   <= r_g6_t1;
        r_g7_t2   <= r_g6_t2;
        r_g7_t3   <= r_g6_t3;
        r_g7_t0   <= r_g6_t0;
    end

    // geometry bundle out
    always_comb begin
        o_geom.width     = r_width;
        o_geom.height    = r_height;
        o_geom.cx        = r_g7_cx;
        o_geom.lx        = r_g7_lx;
        o_geom.h2        = r_g7_h2;
        o_geom.h2mo      = r_g7_h2mo;
        o_geom.hq        = r_g7_hq;
        o_geom.dy_init   = r_g7_dy;
        o_geom.thr_band1 = r_g7_t1;
        o_geom.thr_band2 = r_g7_t2;
        o_geom.thr_band3 = r_g7_t3;
        o_geom.thr_ball  = r_g7_t0;
    end

endmodule

>>> hdl/shaded_circle_overlay_core.sv
// shaded_circle_overlay_core: paints a bouncing shaded ball into a raster RGB stream
// an accepted pixel goes through the offset, square and output registers in that order
// throughput: one pixel per clock unless stalled (three-stage square-and-compare pipe)
// reset clears the pixel, line and phase counters and loads a 640 x 480 frame size
// after reset and after every register write the input is held off while the geometry
// unit recomputes; depends on scov_pkg and scov_geometry
module shaded_circle_overlay_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [scov_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [scov_pkg::CFG_W-1:0]      i_cfg_wdata,
    // pixel in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,   // in_red, in_green, in_blue
    // pixel out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,   // out_red, out_green, out_blue
    output logic                            m_axis_tlast    // frame_end
);

    localparam int CW = ((COORD_BITS + 1) > scov_pkg::CFG_W) ? (COORD_BITS + 1)
                                                              : scov_pkg::CFG_W;
    localparam int DW = ((COORD_BITS > scov_pkg::GEOM_W) ? COORD_BITS
                                                         : scov_pkg::GEOM_W) + 1;
    localparam int SW = 2 * DW + 1;

    scov_pkg::t_geom w_geom;
    logic            w_busy;

    logic [COORD_BITS-1:0]         r_col, r_row;
    logic [scov_pkg::PHASE_W-1:0]  r_phase;
    logic signed [scov_pkg::DY_W-1:0] r_dy, n_dy;
    logic [scov_pkg::GEOM_W-1:0]   r_cy, r_ly, n_cy, n_ly, w_dy_abs;

    logic w_accept, w_line_end, w_frame_end;
    logic w_en1, w_en2, w_en3;
    logic r_v1, r_v2, r_v3;

    scov_geometry u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_phase     (r_phase),
        .o_geom      (w_geom),
        .o_busy      (w_busy)
    );

    // pipeline flow: each stage moves when the one after it is free or moving
    assign w_en3         = !r_v3 || m_axis_tready;
    assign w_en2         = !r_v2 || w_en3;
    assign w_en1         = !r_v1 || w_en2;
    assign s_axis_tready = !w_busy && w_en1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // line and frame end detection
    assign w_line_end  = (CW'(r_col) + CW'(1)) >= CW'(w_geom.width);
    assign w_frame_end = w_line_end && ((CW'(r_row) + CW'(1)) >= CW'(w_geom.height));

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (w_accept) begin
            if (w_line_end) begin
                r_col <= '0;
                if (w_frame_end) begin
                    r_row   <= '0;
                    r_phase <= (r_phase == scov_pkg::PHASE_LAST) ? '0
                             : r_phase + scov_pkg::PHASE_W'(1);
                end else begin
                    r_row <= r_row + COORD_BITS'(1);
                end
            end else begin
                r_col <= r_col + COORD_BITS'(1);
            end
        end
    end

    // ball row: vertical offset stepped once a frame, loaded while geometry settles
    always_comb begin
        n_dy = r_dy;
        if (w_busy) begin
            n_dy = w_geom.dy_init;
        end else if (w_accept && w_frame_end) begin
            if (r_phase == scov_pkg::PHASE_LAST) begin
                n_dy = scov_pkg::DY_W'(w_geom.h2);
            end else begin
                n_dy = r_dy - scov_pkg::DY_W'(w_geom.hq);
            end
        end
        w_dy_abs = n_dy[scov_pkg::DY_W-1] ? scov_pkg::GEOM_W'(-n_dy)
                                           : scov_pkg::GEOM_W'(n_dy);
        n_cy = w_dy_abs + scov_pkg::GEOM_W'(w_geom.h2);
        n_ly = w_dy_abs + scov_pkg::GEOM_W'(w_geom.h2mo);
    end

    always_ff @(posedge i_clk) begin
        r_dy <= n_dy;
        r_cy <= n_cy;
        r_ly <= n_ly;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= w_accept;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // stage 1: offsets from both centres
    logic signed [DW-1:0] r_s1_dx, r_s1_dy, r_s1_lx, r_s1_ly;
    logic [23:0]          r_s1_pix;
    logic                 r_s1_fe;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_dx  <= $signed(DW'(w_geom.cx)) - $signed(DW'(r_col));
            r_s1_dy  <= $signed(DW'(r_cy)) - $signed(DW'(r_row));
            r_s1_lx  <= $signed(DW'(w_geom.lx)) - $signed(DW'(r_col));
            r_s1_ly  <= $signed(DW'(r_ly)) - $signed(DW'(r_row));
            r_s1_pix <= s_axis_tdata;
            r_s1_fe  <= w_frame_end;
        end
    end

    // stage 2: squares
    logic signed [2*DW-1:0] r_s2_dx2, r_s2_dy2, r_s2_lx2, r_s2_ly2;
    logic [23:0]            r_s2_pix;
    logic                   r_s2_fe;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_dx2 <= (2*DW)'(r_s1_dx) * (2*DW)'(r_s1_dx);
            r_s2_dy2 <= (2*DW)'(r_s1_dy) * (2*DW)'(r_s1_dy);
            r_s2_lx2 <= (2*DW)'(r_s1_lx) * (2*DW)'(r_s1_lx);
            r_s2_ly2 <= (2*DW)'(r_s1_ly) * (2*DW)'(r_s1_ly);
            r_s2_pix <= r_s1_pix;
            r_s2_fe  <= r_s1_fe;
        end
    end

    // stage 3: distance sums, band tests and colour choice
    logic [SW-1:0] w_d2, w_d2l;
    logic [23:0]   n_pix;

    always_comb begin
        w_d2  = SW'($unsigned(r_s2_dx2)) + SW'($unsigned(r_s2_dy2));
        w_d2l = SW'($unsigned(r_s2_lx2)) + SW'($unsigned(r_s2_ly2));
        n_pix = r_s2_pix;
        if (w_d2l < SW'(w_geom.thr_band1)) begin
            n_pix = {scov_pkg::COL_BAND1, scov_pkg::COL_BAND1, scov_pkg::COL_FULL};
        end else if (w_d2l < SW'(w_geom.thr_band2)) begin
            n_pix = {scov_pkg::COL_BAND2, scov_pkg::COL_BAND2, scov_pkg::COL_FULL};
        end else if (w_d2l < SW'(w_geom.thr_band3)) begin
            n_pix = {scov_pkg::COL_BAND3, scov_pkg::COL_BAND3, scov_pkg::COL_FULL};
        end else if (w_d2 < SW'(w_geom.thr_ball)) begin
            n_pix = {scov_pkg::COL_BALL, scov_pkg::COL_BALL, scov_pkg::COL_FULL};
        end
    end

    logic [23:0] r_out_pix;
    logic        r_out_fe;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_out_pix <= n_pix;
            r_out_fe  <= r_s2_fe;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_fe;

    // no pixel is taken while the geometry is settling
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("pixel accepted while geometry settling");

    // a register write holds the input off on the next cycle
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> w_busy)
        else $error("register write did not restart geometry settle");

    // a frame end returns both counters to the origin
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_frame_end) |=> (r_col == '0 && r_row == '0))
        else $error("counters not cleared at frame end");

    // phase stays below its modulus
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= scov_pkg::PHASE_LAST)
        else $error("frame phase out of range");

endmodule

>>> test/shaded_circle_overlay_core_test.sv
`timescale 1ns / 1ps
// shaded_circle_overlay_core_test: self-checking bench for the shaded ball overlay core
// drives pixel streams and frame sizes, predicts each output pixel and compares it
// depends on scov_pkg and shaded_circle_overlay_core
module shaded_circle_overlay_core_test;

    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // which part of the ball a pixel landed in
    typedef enum int {
        SHADE_CORE,
        SHADE_MID,
        SHADE_RIM,
        SHADE_BALL,
        SHADE_NONE
    } t_shade;

    // receiver ready patterns
    typedef enum int {
        SINK_FREE,
        SINK_HALF,
        SINK_RARE,
        SINK_BURSTY
    } t_sink_mode;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
        t_shade     shade;
    } t_pixel_out;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [scov_pkg::CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [scov_pkg::CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [23:0]                     s_axis_tdata  = '0;   // in_red, in_green, in_blue
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [23:0]                     m_axis_tdata;         // out_red, out_green, out_blue
    logic                            m_axis_tlast;         // frame_end

    // predictor copy of the registers and counters
    logic [scov_pkg::CFG_W-1:0]   cfg_width  = scov_pkg::WIDTH_RESET;
    logic [scov_pkg::CFG_W-1:0]   cfg_height = scov_pkg::HEIGHT_RESET;
    logic [11:0]                  pix_col    = '0;
    logic [11:0]                  pix_row    = '0;
    logic [scov_pkg::PHASE_W-1:0] pix_phase  = '0;

    t_pixel_out expected_pixels[$];

    int items_sent      = 0;
    int pixels_checked  = 0;
    int error_count     = 0;
    int frame_ends      = 0;
    int reg_writes      = 0;
    int burst_left      = 0;
    int hold_asked      = 0;
    int hold_taken      = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int shade_hits[5]   = '{default: 0};

    t_sink_mode sink_mode  = SINK_FREE;
    int         sink_left  = 0;
    logic [2:0] sink_tick  = '0;

    shaded_circle_overlay_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still pending",
                     cycle_count, expected_pixels.size());
            $display("shaded_circle_overlay_core_test failed");
            $finish;
        end
    end

    // ball centre, radius and highlight offset for a frame size and phase
    function automatic void ball_geometry(input longint w, input longint h, input longint ph,
                                          output longint cx, output longint cy,
                                          output longint r, output longint o);
        longint dy;
        cx = w / 2;
        dy = h / 2 - (h / 60) * ph;
        cy = (dy < 0 ? -dy : dy) + h / 2;
        r  = (h < w ? h : w) / 10;
        o  = 0;
        while (8 * (o + 1) * (o + 1) <= r * r)
            o++;
    endfunction

    // expected output for one pixel, then step the column, row and phase counters
    function automatic t_pixel_out shade_pixel(input logic [23:0] rgb);
        t_pixel_out res;
        longint w, h, ph, cx, cy, r, o, px, py, d2, d2l, k;
        logic line_end;
        w  = cfg_width;
        h  = cfg_height;
        ph = pix_phase;
        px = pix_col;
        py = pix_row;
        ball_geometry(w, h, ph, cx, cy, r, o);
        d2  = (cx - px) * (cx - px) + (cy - py) * (cy - py);
        d2l = (cx - o - px) * (cx - o - px) + (cy - o - py) * (cy - o - py);

        res.red   = rgb[7:0];
        res.green = rgb[15:8];
        res.blue  = rgb[23:16];
        res.shade = SHADE_NONE;
        // floor(sqrt(d)) <= k is d < (k+1)^2, first band that matches wins
        k = r / 6;
        if (d2l < (k + 1) * (k + 1)) begin
            res.shade = SHADE_CORE;
        end else begin
            k = r / 4;
            if (d2l < (k + 1) * (k + 1)) begin
                res.shade = SHADE_MID;
            end else begin
                k = r / 3;
                if (d2l < (k + 1) * (k + 1))
                    res.shade = SHADE_RIM;
                else if (d2 < (r + 1) * (r + 1))
                    res.shade = SHADE_BALL;
            end
        end
        case (res.shade)
            SHADE_CORE: begin
                res.red   = scov_pkg::COL_FULL;
                res.green = scov_pkg::COL_BAND1;
                res.blue  = scov_pkg::COL_BAND1;
            end
            SHADE_MID: begin
                res.red   = scov_pkg::COL_FULL;
                res.green = scov_pkg::COL_BAND2;
                res.blue  = scov_pkg::COL_BAND2;
            end
            SHADE_RIM: begin
                res.red   = scov_pkg::COL_FULL;
                res.green = scov_pkg::COL_BAND3;
                res.blue  = scov_pkg::COL_BAND3;
            end
            SHADE_BALL: begin
                res.red   = scov_pkg::COL_FULL;
                res.green = scov_pkg::COL_BALL;
                res.blue  = scov_pkg::COL_BALL;
            end
            default: ;
        endcase

        // a counter already past a shrunken size closes its line or frame at once
        line_end      = (px + 1 >= w);
        res.frame_end = line_end && (py + 1 >= h);
        if (line_end) begin
            pix_col = '0;
            if (res.frame_end) begin
                pix_row   = '0;
                pix_phase = (pix_phase >= scov_pkg::PHASE_LAST) ? '0 : pix_phase + 1'b1;
            end else begin
                pix_row = pix_row + 1'b1;
            end
        end else begin
            pix_col = pix_col + 1'b1;
        end
        return res;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // offer one pixel in bursts with random gaps, predict it once the transfer happens
    task automatic push_pixel(input logic [23:0] rgb);
        int gap;
        t_pixel_out want;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rgb;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        want = shade_pixel(rgb);
        shade_hits[int'(want.shade)]++;
        if (want.frame_end)
            frame_ends++;
        expected_pixels.push_back(want);
        items_sent++;
    endtask

    // random pixels, none once the item target is reached
    task automatic push_random(input int count);
        repeat (count) begin
            if (items_sent < ITEM_TARGET)
                push_pixel(24'($urandom_range(0, 24'hFFFFFF)));
        end
    endtask

    // register write once the pipe has drained
    task automatic write_frame_reg(input scov_pkg::t_cfg_idx idx,
                                   input logic [scov_pkg::CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == scov_pkg::CFG_FRAME_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
        reg_writes++;
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                flag_error($sformatf("output transfer with nothing pending, tdata %h",
                                     m_axis_tdata));
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.red)
                    flag_error($sformatf("pixel %0d red %h, predicted %h",
                                         pixels_checked, m_axis_tdata[7:0], want.red));
                if (m_axis_tdata[15:8] !== want.green)
                    flag_error($sformatf("pixel %0d green %h, predicted %h",
                                         pixels_checked, m_axis_tdata[15:8], want.green));
                if (m_axis_tdata[23:16] !== want.blue)
                    flag_error($sformatf("pixel %0d blue %h, predicted %h",
                                         pixels_checked, m_axis_tdata[23:16], want.blue));
                if (m_axis_tlast !== want.frame_end)
                    flag_error($sformatf("pixel %0d frame end %b, predicted %b",
                                         pixels_checked, m_axis_tlast, want.frame_end));
            end
            pixels_checked++;
        end
    end

    // receiver: changing ready patterns, plus a long hold-off on request
    always @(posedge i_clk) begin
        sink_tick <= sink_tick + 1'b1;
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken    <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_mode <= t_sink_mode'($urandom_range(0, 3));
                sink_left <= $urandom_range(16, 96);
            end else begin
                sink_left <= sink_left - 1;
            end
            case (sink_mode)
                SINK_FREE:   m_axis_tready <= 1'b1;
                SINK_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                SINK_RARE:   m_axis_tready <= ($urandom_range(0, 9) != 0);
                SINK_BURSTY: m_axis_tready <= (sink_tick < 3'd5);
                default:     m_axis_tready <= 1'b1;
            endcase
        end
    end

    // default 640 x 480 frame, pass-through corner pixels and a mid-line shrink
    task automatic test_power_on_frame();
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h555555);
        push_pixel(24'hAAAAAA);
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, 12'd2);
        push_random(2);
    endtask

    // zero and full-scale sizes in both registers
    task automatic test_size_extremes();
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, 12'd0);
        write_frame_reg(scov_pkg::CFG_FRAME_HEIGHT, 12'd0);
        push_random(3);
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, 12'd4095);
        write_frame_reg(scov_pkg::CFG_FRAME_HEIGHT, 12'd4095);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_random(1);
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, 12'd0);
        write_frame_reg(scov_pkg::CFG_FRAME_HEIGHT, 12'd3);
        push_random(4);
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, 12'd4095);
        write_frame_reg(scov_pkg::CFG_FRAME_HEIGHT, 12'd0);
        push_random(2);
    endtask

    // one-pixel frames walk the phase through 59 and back to 0
    task automatic test_phase_wrap();
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, 12'd1);
        write_frame_reg(scov_pkg::CFG_FRAME_HEIGHT, 12'd1);
        push_random(62);
    endtask

    // long receiver stall while pixels keep coming, so the core stops taking input
    task automatic test_output_backpressure();
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, 12'd64);
        write_frame_reg(scov_pkg::CFG_FRAME_HEIGHT, 12'd64);
        push_random(10);
        hold_asked++;
        push_random(40);
    endtask

    // set a phase, jump to the rows over the ball and cross it line by line
    task automatic sweep_ball(input logic [scov_pkg::CFG_W-1:0] ball_w,
                              input logic [scov_pkg::CFG_W-1:0] ball_h);
        longint cx, cy, r, o, first_row;
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, 12'd1);
        write_frame_reg(scov_pkg::CFG_FRAME_HEIGHT, 12'd1);
        push_random(int'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 60)
                                                      : $urandom_range(1, 8)));
        ball_geometry(ball_w, ball_h, pix_phase, cx, cy, r, o);
        first_row = cy - r - 1 + $urandom_range(0, r);
        if (first_row < 0)
            first_row = 0;
        if (first_row > ball_h - 1)
            first_row = ball_h - 1;
        // one-pixel lines move down a row per transfer
        write_frame_reg(scov_pkg::CFG_FRAME_HEIGHT, ball_h);
        push_random(int'(first_row));
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, ball_w);
        repeat ($urandom_range(3, 6)) begin
            push_random(int'(cx + r + 1 + $urandom_range(0, 3)));
            // close the line early rather than stream its right half
            write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, 12'd1);
            push_random(1);
            write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, ball_w);
        end
    endtask

    // small frame sizes, and thin ones with the long side up to 4095, with random pixels
    task automatic shuffle_frames();
        logic [scov_pkg::CFG_W-1:0] w, h;
        case ($urandom_range(0, 5))
            0: begin
                w = scov_pkg::CFG_W'($urandom_range(0, 4095));
                h = scov_pkg::CFG_W'($urandom_range(0, 3));
            end
            1: begin
                w = scov_pkg::CFG_W'($urandom_range(0, 3));
                h = scov_pkg::CFG_W'($urandom_range(0, 4095));
            end
            default: begin
                w = scov_pkg::CFG_W'($urandom_range(0, 12));
                h = scov_pkg::CFG_W'($urandom_range(0, 6));
            end
        endcase
        write_frame_reg(scov_pkg::CFG_FRAME_WIDTH, w);
        write_frame_reg(scov_pkg::CFG_FRAME_HEIGHT, h);
        push_random(int'($urandom_range(20, 60)));
    endtask

    task automatic test_random_frames();
        int size_class;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 6) begin
                size_class = $urandom_range(0, 19);
                if (size_class < 9)
                    sweep_ball(scov_pkg::CFG_W'($urandom_range(60, 80)),
                               scov_pkg::CFG_W'($urandom_range(60, 80)));
                else if (size_class < 16)
                    sweep_ball(scov_pkg::CFG_W'($urandom_range(80, 100)),
                               scov_pkg::CFG_W'($urandom_range(80, 100)));
                else
                    sweep_ball(scov_pkg::CFG_W'($urandom_range(120, 136)),
                               scov_pkg::CFG_W'($urandom_range(120, 136)));
            end else begin
                shuffle_frames();
            end
        end
    endtask

    // sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_on_frame();
        test_size_extremes();
        test_phase_wrap();
        test_output_backpressure();
        test_random_frames();

        // drain
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("covered %0d pixel transfers, %0d frame ends and %0d register writes",
                 items_sent, frame_ends, reg_writes);
        $display("shading seen: core %0d, mid %0d, rim %0d, ball %0d, unchanged %0d",
                 shade_hits[SHADE_CORE], shade_hits[SHADE_MID], shade_hits[SHADE_RIM],
                 shade_hits[SHADE_BALL], shade_hits[SHADE_NONE]);
        if (error_count == 0) begin
            $display("shaded_circle_overlay_core_test passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("shaded_circle_overlay_core_test failed");
        end
        $finish;
    end

endmodule
